[design/c8_pkg.sv]
// Shared types, constants and helper functions for the CHIP-8 instruction core.
// Used by the core and the port checker; depends on nothing.
`default_nettype none

package c8_pkg;

    localparam int MEMORY_DEPTH   = 4096;
    localparam int PROGRAM_START  = 512;
    localparam int STACK_DEPTH    = 16;
    localparam int SCREEN_COLUMNS = 64;
    localparam int SCREEN_LINES   = 32;

    localparam int ADDR_W   = 12;
    localparam int BYTE_W   = 8;
    localparam int NREGS    = 16;
    localparam int RIDX_W   = 4;
    localparam int LINE_W   = $clog2(SCREEN_LINES);
    localparam int COL_W    = $clog2(SCREEN_COLUMNS);
    localparam int KIND_W   = 3;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 112;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_KEY   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EXEC  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ROW   = 3'd5;

    localparam logic [3:0] OP_SYS    = 4'h0;
    localparam logic [3:0] OP_JP     = 4'h1;
    localparam logic [3:0] OP_CALL   = 4'h2;
    localparam logic [3:0] OP_SE_K   = 4'h3;
    localparam logic [3:0] OP_SNE_K  = 4'h4;
    localparam logic [3:0] OP_SE_V   = 4'h5;
    localparam logic [3:0] OP_LD_K   = 4'h6;
    localparam logic [3:0] OP_ADD_K  = 4'h7;
    localparam logic [3:0] OP_ALU    = 4'h8;
    localparam logic [3:0] OP_SNE_V  = 4'h9;
    localparam logic [3:0] OP_LD_I   = 4'hA;
    localparam logic [3:0] OP_JP_V0  = 4'hB;
    localparam logic [3:0] OP_RND    = 4'hC;
    localparam logic [3:0] OP_DRAW   = 4'hD;
    localparam logic [3:0] OP_KEY    = 4'hE;
    localparam logic [3:0] OP_MISC   = 4'hF;

    localparam logic [7:0] SYS_CLS   = 8'hE0;
    localparam logic [7:0] SYS_RET   = 8'hEE;

    localparam logic [3:0] ALU_MOV   = 4'h0;
    localparam logic [3:0] ALU_OR    = 4'h1;
    localparam logic [3:0] ALU_AND   = 4'h2;
    localparam logic [3:0] ALU_XOR   = 4'h3;
    localparam logic [3:0] ALU_ADD   = 4'h4;
    localparam logic [3:0] ALU_SUB   = 4'h5;
    localparam logic [3:0] ALU_SHR   = 4'h6;
    localparam logic [3:0] ALU_SUBN  = 4'h7;
    localparam logic [3:0] ALU_SHL   = 4'hE;

    localparam logic [7:0] KEY_SKP   = 8'h9E;
    localparam logic [7:0] KEY_SKNP  = 8'hA1;

    localparam logic [7:0] MISC_GET_DT = 8'h07;
    localparam logic [7:0] MISC_WAIT   = 8'h0A;
    localparam logic [7:0] MISC_SET_DT = 8'h15;
    localparam logic [7:0] MISC_SET_ST = 8'h18;
    localparam logic [7:0] MISC_ADD_I  = 8'h1E;
    localparam logic [7:0] MISC_FONT   = 8'h29;
    localparam logic [7:0] MISC_BCD    = 8'h33;
    localparam logic [7:0] MISC_STORE  = 8'h55;
    localparam logic [7:0] MISC_LOAD   = 8'h65;

    localparam logic [RIDX_W-1:0] FLAG_REG = 4'hF;
    localparam logic [RIDX_W-1:0] TOP_LVL  = 4'hF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MEM_RD,
        ST_FETCH0,
        ST_FETCH1,
        ST_FETCH2,
        ST_READ_VX,
        ST_READ_VY,
        ST_EXEC,
        ST_DRAW_RD,
        ST_DRAW_ROW,
        ST_BCD,
        ST_BLOCK_WR,
        ST_LOAD_RD,
        ST_LOAD_WR,
        ST_FINISH
    } c8_state_t;

    function automatic logic [11:0] c8_bcd(input logic [7:0] v);
        logic [19:0] s;
        s = {12'd0, v};
        for (int i = 0; i < 8; i++) begin
            for (int d = 0; d < 3; d++) begin
                if (s[8 + 4 * d +: 4] >= 4'd5) begin
                    s[8 + 4 * d +: 4] = s[8 + 4 * d +: 4] + 4'd3;
                end
            end
            s = s << 1;
        end
        return s[19:8];
    endfunction

    function automatic logic [SCREEN_COLUMNS-1:0] c8_sprite_mask(input logic [7:0] sprite,
                                                                 input logic [COL_W-1:0] col);
        logic [SCREEN_COLUMNS-1:0] b;
        b = {sprite, {(SCREEN_COLUMNS - 8){1'b0}}};
        return (b >> col) | (b << ((COL_W + 1)'(SCREEN_COLUMNS) - {1'b0, col}));
    endfunction

endpackage

`default_nettype wire

[design/c8_ram.sv]
// Generic single-port RAM with registered read data.
// Stand-alone; used by the CHIP-8 core for its byte memory.
`default_nettype none

module c8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/chip8_instruction_core.sv]
// CHIP-8 interpreter core: sequencer, register file, stack, timers, keys and frame buffer.
// Depends on c8_pkg and c8_ram.
//
//  channel | ports              | payload
//  --------+--------------------+-----------------------------------------------
//  request | s_tvalid/s_tready  | s_tuser kind, s_tdata item fields
//  result  | m_tvalid/m_tready  | m_tdata machine state after the request
//
// A load, set-key, tick or row read runs dispatch and finish; a byte read adds a memory
// read. An instruction runs fetch, operand reads and execute; a draw adds a read and a
// row update per sprite row, Fx55 stores V0..Vx, Fx65 loads V0..Vx, Fx33 writes 3 digits,
// all via the single memory port. Reset restores the registers and clears the screen at
// once. A stalled result is held in an output register while the next request runs.
`default_nettype none

module chip8_instruction_core #(
    parameter int MEMORY_DEPTH  = c8_pkg::MEMORY_DEPTH,
    parameter int PROGRAM_START = c8_pkg::PROGRAM_START
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // address[11:0], data[19:12], key_index[23:20], key_down[24],
    // random_byte[32:25], row_index[37:33], zero fill
    input  wire logic [c8_pkg::S_DATA_W-1:0]   s_tdata,
    // kind[2:0]
    input  wire logic [c8_pkg::KIND_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // program_counter[11:0], index_value[23:12], read_data[31:24],
    // row_pixels[95:32], flag_value[103:96], waiting_for_key[104],
    // sound_active[105], zero fill
    output logic      [c8_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int MEM_AW = $clog2(MEMORY_DEPTH);
    localparam int AW     = c8_pkg::ADDR_W;
    localparam int COLS   = c8_pkg::SCREEN_COLUMNS;

    c8_pkg::c8_state_t state_reg, state_next;

    logic [c8_pkg::KIND_W-1:0] kind_reg;
    logic [AW-1:0]             addr_in_reg;
    logic [7:0]                data_in_reg;
    logic [3:0]                key_in_reg;
    logic                      down_in_reg;
    logic [7:0]                rnd_reg;
    logic [c8_pkg::LINE_W-1:0] row_in_reg;

    logic [7:0] op_hi_reg, op_lo_reg, vx_reg, vy_reg;
    logic [3:0] cnt_reg;
    logic       hit_reg;

    logic [7:0]      regs_reg  [c8_pkg::NREGS];
    logic [AW-1:0]   index_reg, pc_reg;
    logic [AW-1:0]   stack_reg [c8_pkg::STACK_DEPTH];
    logic [3:0]      level_reg;
    logic [7:0]      delay_reg, sound_reg;
    logic [15:0]     keys_reg;
    logic [COLS-1:0] frame_reg [c8_pkg::SCREEN_LINES];
    logic            wait_reg;
    logic [3:0]      target_reg;

    logic [7:0]                  rd_reg;
    logic [COLS-1:0]             pix_reg;
    logic                        out_valid_reg;
    logic [c8_pkg::M_DATA_W-1:0] out_data_reg;

    logic [3:0]  grp, x_idx, y_idx, n_val;
    logic [7:0]  kk;
    logic [AW-1:0] nnn;
    assign grp   = op_hi_reg[7:4];
    assign x_idx = op_hi_reg[3:0];
    assign y_idx = op_lo_reg[7:4];
    assign n_val = op_lo_reg[3:0];
    assign kk    = op_lo_reg;
    assign nnn   = {op_hi_reg[3:0], op_lo_reg};

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata, mem_rdata;
    logic [3:0]    rf_raddr;
    logic [7:0]    rf_rdata;

    c8_ram #(
        .WIDTH (c8_pkg::BYTE_W),
        .DEPTH (MEMORY_DEPTH)
    ) u_mem (
        .clk   (aclk),
        .we    (mem_we),
        .addr  (MEM_AW'(mem_addr)),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    logic [AW-1:0]             pc_plus2, pc_plus4, i_plus_cnt, exec_pc, stack_top;
    logic [c8_pkg::LINE_W-1:0] draw_line, frame_sel;
    logic [COLS-1:0]           frame_rd, mask;
    logic                      key_hit, slot_free, draw_hit;
    logic [7:0]                alu_a, alu_b;
    logic                      alu_sub;
    logic [8:0]                alu_sum;
    logic [AW:0]               i_sum;
    logic [11:0]               digits;

    assign pc_plus2   = pc_reg + AW'(2);
    assign pc_plus4   = pc_reg + AW'(4);
    assign i_plus_cnt = index_reg + AW'(cnt_reg);
    assign stack_top  = stack_reg[level_reg - 4'd1];
    assign draw_line  = vy_reg[c8_pkg::LINE_W-1:0] + c8_pkg::LINE_W'(cnt_reg);
    assign frame_sel  = (state_reg == c8_pkg::ST_DRAW_ROW) ? draw_line : row_in_reg;
    assign frame_rd   = frame_reg[frame_sel];
    assign mask       = c8_pkg::c8_sprite_mask(mem_rdata, vx_reg[c8_pkg::COL_W-1:0]);
    assign draw_hit   = hit_reg | (|(frame_rd & mask));
    assign key_hit    = keys_reg[vx_reg[3:0]];
    assign rf_rdata   = regs_reg[rf_raddr];
    assign slot_free  = !out_valid_reg || m_tready;
    assign i_sum      = {1'b0, index_reg} + (AW + 1)'(vx_reg);
    assign digits     = c8_pkg::c8_bcd(vx_reg);
    assign alu_sum    = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + 9'(alu_sub);

    always_comb begin
        alu_a   = vx_reg;
        alu_b   = vy_reg;
        alu_sub = 1'b0;
        if (grp == c8_pkg::OP_ADD_K) begin
            alu_b = kk;
        end else if (n_val == c8_pkg::ALU_SUB) begin
            alu_sub = 1'b1;
        end else if (n_val == c8_pkg::ALU_SUBN) begin
            alu_a   = vy_reg;
            alu_b   = vx_reg;
            alu_sub = 1'b1;
        end
    end

    always_comb begin
        exec_pc = pc_plus2;
        case (grp)
            c8_pkg::OP_SYS: begin
                if (kk == c8_pkg::SYS_RET && level_reg != 4'd0) begin
                    exec_pc = stack_top + AW'(2);
                end
            end
            c8_pkg::OP_JP, c8_pkg::OP_CALL: exec_pc = nnn;
            c8_pkg::OP_SE_K:  if (vx_reg == kk) exec_pc = pc_plus4;
            c8_pkg::OP_SNE_K: if (vx_reg != kk) exec_pc = pc_plus4;
            c8_pkg::OP_SE_V:  if (vx_reg == vy_reg) exec_pc = pc_plus4;
            c8_pkg::OP_SNE_V: if (vx_reg != vy_reg) exec_pc = pc_plus4;
            c8_pkg::OP_JP_V0: exec_pc = nnn + AW'(vy_reg);
            c8_pkg::OP_KEY: begin
                if ((kk == c8_pkg::KEY_SKP && key_hit) || (kk == c8_pkg::KEY_SKNP && !key_hit)) begin
                    exec_pc = pc_plus4;
                end
            end
            default: exec_pc = pc_plus2;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            c8_pkg::ST_IDLE:     if (s_tvalid) state_next = c8_pkg::ST_DISPATCH;
            c8_pkg::ST_DISPATCH: begin
                if (kind_reg == c8_pkg::KIND_READ) begin
                    state_next = c8_pkg::ST_MEM_RD;
                end else if (kind_reg == c8_pkg::KIND_EXEC && !wait_reg) begin
                    state_next = c8_pkg::ST_FETCH0;
                end else begin
                    state_next = c8_pkg::ST_FINISH;
                end
            end
            c8_pkg::ST_MEM_RD:  state_next = c8_pkg::ST_FINISH;
            c8_pkg::ST_FETCH0:  state_next = c8_pkg::ST_FETCH1;
            c8_pkg::ST_FETCH1:  state_next = c8_pkg::ST_FETCH2;
            c8_pkg::ST_FETCH2:  state_next = c8_pkg::ST_READ_VX;
            c8_pkg::ST_READ_VX: state_next = c8_pkg::ST_READ_VY;
            c8_pkg::ST_READ_VY: state_next = c8_pkg::ST_EXEC;
            c8_pkg::ST_EXEC: begin
                state_next = c8_pkg::ST_FINISH;
                if (grp == c8_pkg::OP_DRAW && n_val != 4'd0) begin
                    state_next = c8_pkg::ST_DRAW_RD;
                end else if (grp == c8_pkg::OP_MISC) begin
                    if (kk == c8_pkg::MISC_BCD) state_next = c8_pkg::ST_BCD;
                    else if (kk == c8_pkg::MISC_STORE) state_next = c8_pkg::ST_BLOCK_WR;
                    else if (kk == c8_pkg::MISC_LOAD) state_next = c8_pkg::ST_LOAD_RD;
                end
            end
            c8_pkg::ST_DRAW_RD:  state_next = c8_pkg::ST_DRAW_ROW;
            c8_pkg::ST_DRAW_ROW: begin
                state_next = (cnt_reg == n_val - 4'd1) ? c8_pkg::ST_FINISH : c8_pkg::ST_DRAW_RD;
            end
            c8_pkg::ST_BCD: begin
                state_next = (cnt_reg == 4'd2) ? c8_pkg::ST_FINISH : c8_pkg::ST_BCD;
            end
            c8_pkg::ST_BLOCK_WR: begin
                state_next = (cnt_reg == x_idx) ? c8_pkg::ST_FINISH : c8_pkg::ST_BLOCK_WR;
            end
            c8_pkg::ST_LOAD_RD:  state_next = c8_pkg::ST_LOAD_WR;
            c8_pkg::ST_LOAD_WR: begin
                state_next = (cnt_reg == x_idx) ? c8_pkg::ST_FINISH : c8_pkg::ST_LOAD_RD;
            end
            c8_pkg::ST_FINISH:   if (slot_free) state_next = c8_pkg::ST_IDLE;
            default:             state_next = c8_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = i_plus_cnt;
        mem_wdata = rf_rdata;
        rf_raddr  = x_idx;
        unique case (state_reg)
            c8_pkg::ST_DISPATCH: begin
                mem_addr  = addr_in_reg;
                mem_we    = (kind_reg == c8_pkg::KIND_LOAD);
                mem_wdata = data_in_reg;
            end
            c8_pkg::ST_FETCH0:  mem_addr = pc_reg;
            c8_pkg::ST_FETCH1:  mem_addr = pc_reg + AW'(1);
            c8_pkg::ST_READ_VY: rf_raddr = (grp == c8_pkg::OP_JP_V0) ? 4'd0 : y_idx;
            c8_pkg::ST_BCD: begin
                mem_we = 1'b1;
                case (cnt_reg)
                    4'd0:    mem_wdata = {4'd0, digits[11:8]};
                    4'd1:    mem_wdata = {4'd0, digits[7:4]};
                    default: mem_wdata = {4'd0, digits[3:0]};
                endcase
            end
            c8_pkg::ST_BLOCK_WR: begin
                mem_we   = 1'b1;
                rf_raddr = cnt_reg;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= c8_pkg::ST_IDLE;
            index_reg     <= '0;
            pc_reg        <= AW'(PROGRAM_START);
            level_reg     <= '0;
            delay_reg     <= '0;
            sound_reg     <= '0;
            keys_reg      <= '0;
            wait_reg      <= 1'b0;
            target_reg    <= '0;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < c8_pkg::NREGS; i++) regs_reg[i] <= '0;
            for (int i = 0; i < c8_pkg::STACK_DEPTH; i++) stack_reg[i] <= '0;
            for (int i = 0; i < c8_pkg::SCREEN_LINES; i++) frame_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == c8_pkg::ST_FINISH && slot_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                c8_pkg::ST_DISPATCH: begin
                    if (kind_reg == c8_pkg::KIND_KEY) begin
                        keys_reg[key_in_reg] <= down_in_reg;
                        if (down_in_reg && wait_reg) begin
                            regs_reg[target_reg] <= {4'd0, key_in_reg};
                            wait_reg             <= 1'b0;
                        end
                    end else if (kind_reg == c8_pkg::KIND_TICK) begin
                        if (sound_reg != 8'd0) sound_reg <= sound_reg - 8'd1;
                        if (delay_reg != 8'd0) delay_reg <= delay_reg - 8'd1;
                    end
                end
                c8_pkg::ST_EXEC: begin
                    cnt_reg <= '0;
                    hit_reg <= 1'b0;
                    pc_reg  <= exec_pc;
                    case (grp)
                        c8_pkg::OP_SYS: begin
                            if (kk == c8_pkg::SYS_CLS) begin
                                for (int i = 0; i < c8_pkg::SCREEN_LINES; i++) frame_reg[i] <= '0;
                            end else if (kk == c8_pkg::SYS_RET && level_reg != 4'd0) begin
                                level_reg <= level_reg - 4'd1;
                            end
                        end
                        c8_pkg::OP_CALL: begin
                            stack_reg[level_reg] <= pc_reg;
                            if (level_reg != c8_pkg::TOP_LVL) level_reg <= level_reg + 4'd1;
                        end
                        c8_pkg::OP_LD_K:  regs_reg[x_idx] <= kk;
                        c8_pkg::OP_ADD_K: regs_reg[x_idx] <= alu_sum[7:0];
                        c8_pkg::OP_ALU: begin
                            case (n_val)
                                c8_pkg::ALU_MOV: regs_reg[x_idx] <= vy_reg;
                                c8_pkg::ALU_OR:  regs_reg[x_idx] <= vx_reg | vy_reg;
                                c8_pkg::ALU_AND: regs_reg[x_idx] <= vx_reg & vy_reg;
                                c8_pkg::ALU_XOR: regs_reg[x_idx] <= vx_reg ^ vy_reg;
                                c8_pkg::ALU_ADD: begin
                                    regs_reg[x_idx]            <= alu_sum[7:0];
                                    regs_reg[c8_pkg::FLAG_REG] <= {7'd0, alu_sum[8]};
                                end
                                c8_pkg::ALU_SUB, c8_pkg::ALU_SUBN: begin
                                    regs_reg[x_idx]            <= alu_sum[7:0];
                                    regs_reg[c8_pkg::FLAG_REG] <=
                                        {7'd0, alu_sum[8] && (alu_sum[7:0] != 8'd0)};
                                end
                                c8_pkg::ALU_SHR: begin
                                    regs_reg[x_idx]            <= {1'b0, vx_reg[7:1]};
                                    regs_reg[c8_pkg::FLAG_REG] <= {7'd0, vx_reg[0]};
                                end
                                c8_pkg::ALU_SHL: begin
                                    regs_reg[x_idx]            <= {vx_reg[6:0], 1'b0};
                                    regs_reg[c8_pkg::FLAG_REG] <= {7'd0, vx_reg[7]};
                                end
                                default: ;
                            endcase
                        end
                        c8_pkg::OP_LD_I: index_reg <= nnn;
                        c8_pkg::OP_RND:  regs_reg[x_idx] <= rnd_reg & kk;
                        c8_pkg::OP_DRAW: if (n_val == 4'd0) regs_reg[c8_pkg::FLAG_REG] <= '0;
                        c8_pkg::OP_MISC: begin
                            case (kk)
                                c8_pkg::MISC_GET_DT: regs_reg[x_idx] <= delay_reg;
                                c8_pkg::MISC_WAIT: begin
                                    wait_reg   <= 1'b1;
                                    target_reg <= x_idx;
                                end
                                c8_pkg::MISC_SET_DT: delay_reg <= vx_reg;
                                c8_pkg::MISC_SET_ST: sound_reg <= vx_reg;
                                c8_pkg::MISC_ADD_I: begin
                                    if (i_sum[AW]) begin
                                        regs_reg[c8_pkg::FLAG_REG] <= 8'd1;
                                    end else begin
                                        index_reg                  <= i_sum[AW-1:0];
                                        regs_reg[c8_pkg::FLAG_REG] <= 8'd0;
                                    end
                                end
                                c8_pkg::MISC_FONT: index_reg <= (AW'(vx_reg) << 2) + AW'(vx_reg);
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
                c8_pkg::ST_DRAW_ROW: begin
                    frame_reg[draw_line] <= frame_rd ^ mask;
                    hit_reg              <= draw_hit;
                    cnt_reg              <= cnt_reg + 4'd1;
                    if (cnt_reg == n_val - 4'd1) begin
                        regs_reg[c8_pkg::FLAG_REG] <= {7'd0, draw_hit};
                    end
                end
                c8_pkg::ST_BCD, c8_pkg::ST_BLOCK_WR: cnt_reg <= cnt_reg + 4'd1;
                c8_pkg::ST_LOAD_WR: begin
                    regs_reg[cnt_reg] <= mem_rdata;
                    cnt_reg           <= cnt_reg + 4'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg    <= s_tuser;
            addr_in_reg <= s_tdata[11:0];
            data_in_reg <= s_tdata[19:12];
            key_in_reg  <= s_tdata[23:20];
            down_in_reg <= s_tdata[24];
            rnd_reg     <= s_tdata[32:25];
            row_in_reg  <= s_tdata[37:33];
        end
        case (state_reg)
            c8_pkg::ST_DISPATCH: begin
                rd_reg  <= '0;
                pix_reg <= (kind_reg == c8_pkg::KIND_ROW) ? frame_rd : '0;
            end
            c8_pkg::ST_MEM_RD:  rd_reg    <= mem_rdata;
            c8_pkg::ST_FETCH1:  op_hi_reg <= mem_rdata;
            c8_pkg::ST_FETCH2:  op_lo_reg <= mem_rdata;
            c8_pkg::ST_READ_VX: vx_reg    <= rf_rdata;
            c8_pkg::ST_READ_VY: vy_reg    <= rf_rdata;
            c8_pkg::ST_FINISH: begin
                if (slot_free) begin
                    out_data_reg <= {6'd0, (sound_reg != 8'd0), wait_reg,
                                     regs_reg[c8_pkg::FLAG_REG], pix_reg, rd_reg,
                                     index_reg, pc_reg};
                end
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == c8_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

[design/c8_checker.sv]
// Port-level checker for the CHIP-8 instruction core, bound to its top level.
// Depends on c8_pkg for the result width.
`default_nettype none

module c8_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [c8_pkg::M_DATA_W-1:0] m_tdata
);

    // The core works on one request at a time.
    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("core ready right after taking a request");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A new result appears only as the sequencer returns to idle.
    a_result_with_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result raised while core busy");

endmodule

bind chip8_instruction_core c8_checker u_c8_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
